// ===== design/adpalu_pkg.sv =====
// types, codes and shared constants of the arm data-processing alu
// no dependencies; used by every module of the block except adpalu_fifo
`default_nettype none
package adpalu_pkg;

   // opcodes
   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_OP    = 2'd1;
   localparam logic [1:0] ST_BAD_SHIFT = 2'd2;

   // shift kinds
   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   localparam int unsigned WORD_W = 32;

   // classified instruction, front to back
   typedef struct packed {
      logic [3:0]        op;
      logic [1:0]        status;
      logic              set_flags;
      logic [1:0]        shift_kind;
      logic [7:0]        shift_amt;
      logic [WORD_W-1:0] shift_src;
      logic [WORD_W-1:0] rn;
      logic [3:0]        rd;
      logic [3:0]        flags;
   } decoded_type;

   // one result beat
   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic              write_enable;
      logic [3:0]        rd;
      logic [3:0]        flags;
      logic [1:0]        status;
   } result_type;

endpackage
`default_nettype wire

// ===== design/adpalu_fifo.sv =====
// small register queue used between front and back and at the result side
// depends on nothing; width and depth come from the instantiating module
`default_nettype none
module adpalu_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/adpalu_front.sv =====
// front end: checks the opcode and operand-two form and picks shifter inputs
// depends on adpalu_pkg
`default_nettype none
module adpalu_front (
   input  wire logic [3:0]          op,
   input  wire logic                imm_flag,
   input  wire logic                set_flags,
   input  wire logic [11:0]         operand2,
   input  wire logic [31:0]         rn_value,
   input  wire logic [31:0]         rm_value,
   input  wire logic [7:0]          rs_low_byte,
   input  wire logic [3:0]          dest_reg,
   input  wire logic [3:0]          flags_in,
   output adpalu_pkg::decoded_type  decoded
);
   logic valid_op;

   always_comb begin
      unique case (op)
         adpalu_pkg::OP_AND, adpalu_pkg::OP_EOR, adpalu_pkg::OP_SUB,
         adpalu_pkg::OP_RSB, adpalu_pkg::OP_ADD, adpalu_pkg::OP_TST,
         adpalu_pkg::OP_TEQ, adpalu_pkg::OP_CMP, adpalu_pkg::OP_ORR,
         adpalu_pkg::OP_MOV: valid_op = 1'b1;
         default:            valid_op = 1'b0;
      endcase
   end

   always_comb begin
      decoded            = '0;
      decoded.op         = op;
      decoded.set_flags  = set_flags;
      decoded.rn         = rn_value;
      decoded.rd         = dest_reg;
      decoded.flags      = flags_in;
      decoded.shift_src  = rm_value;
      decoded.shift_kind = operand2[6:5];
      decoded.status     = adpalu_pkg::ST_OK;
      priority if (!valid_op) begin
         decoded.status = adpalu_pkg::ST_BAD_OP;
      end else if (imm_flag) begin
         // 8-bit value rotated right by twice the count
         decoded.shift_src  = {24'd0, operand2[7:0]};
         decoded.shift_kind = adpalu_pkg::SH_ROR;
         decoded.shift_amt  = {3'd0, operand2[11:8], 1'b0};
      end else if (!operand2[4]) begin
         decoded.shift_amt = {3'd0, operand2[11:7]};
      end else if (!operand2[7]) begin
         decoded.shift_amt = rs_low_byte;
      end else begin
         decoded.status = adpalu_pkg::ST_BAD_SHIFT;
      end
   end

endmodule
`default_nettype wire

// ===== design/adpalu_back.sv =====
// back end: barrel shifter, adder/logic unit and flag update
// depends on adpalu_pkg
`default_nettype none
module adpalu_back (
   input  wire adpalu_pkg::decoded_type decoded,
   output adpalu_pkg::result_type       executed
);
   logic [31:0] v;
   logic [7:0]  amt;
   logic        cin;
   logic [31:0] b;
   logic        sh_c;
   logic [32:0] lsl_w, lsr_w, asr_w;
   logic [63:0] ror_w;
   logic [31:0] add_x, add_y;
   logic        add_ci;
   logic [32:0] sum;
   logic [31:0] res;
   logic        c;
   logic        big, exact32;

   assign v       = decoded.shift_src;
   assign amt     = decoded.shift_amt;
   assign cin     = decoded.flags[1];
   assign big     = (amt[7:5] != 3'd0);
   assign exact32 = (amt == 8'd32);
   assign lsl_w   = {1'b0, v} << amt[4:0];
   assign lsr_w   = {v, 1'b0} >> amt[4:0];
   assign asr_w   = 33'($signed({v, 1'b0}) >>> amt[4:0]);
   assign ror_w   = {v, v} >> amt[4:0];

   // shifter; a zero amount passes the value and the old carry
   always_comb begin
      b    = v;
      sh_c = cin;
      if (amt != 8'd0) begin
         unique case (decoded.shift_kind)
            adpalu_pkg::SH_LSL: begin
               b    = big ? 32'd0 : lsl_w[31:0];
               sh_c = big ? (exact32 && v[0]) : lsl_w[32];
            end
            adpalu_pkg::SH_LSR: begin
               b    = big ? 32'd0 : lsr_w[32:1];
               sh_c = big ? (exact32 && v[31]) : lsr_w[0];
            end
            adpalu_pkg::SH_ASR: begin
               b    = big ? {32{v[31]}} : asr_w[32:1];
               sh_c = big ? v[31] : asr_w[0];
            end
            default: begin
               b    = ror_w[31:0];
               sh_c = ror_w[31];
            end
         endcase
      end
   end

   // one adder: add, or x + ~y + 1 for the subtracts (carry = not-borrow)
   always_comb begin
      add_x  = decoded.rn;
      add_y  = b;
      add_ci = 1'b0;
      unique case (decoded.op)
         adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP: begin
            add_y  = ~b;
            add_ci = 1'b1;
         end
         adpalu_pkg::OP_RSB: begin
            add_x  = b;
            add_y  = ~decoded.rn;
            add_ci = 1'b1;
         end
         default: ;
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};

   always_comb begin
      res = b;
      c   = sh_c;
      unique case (decoded.op)
         adpalu_pkg::OP_AND, adpalu_pkg::OP_TST: res = decoded.rn & b;
         adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ: res = decoded.rn ^ b;
         adpalu_pkg::OP_ORR:                     res = decoded.rn | b;
         adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP,
         adpalu_pkg::OP_RSB, adpalu_pkg::OP_ADD: begin
            res = sum[31:0];
            c   = sum[32];
         end
         default: res = b;
      endcase
   end

   always_comb begin
      executed              = '0;
      executed.rd           = decoded.rd;
      executed.status       = decoded.status;
      executed.flags        = decoded.flags;
      if (decoded.status == adpalu_pkg::ST_OK) begin
         executed.result       = res;
         executed.write_enable = !(decoded.op == adpalu_pkg::OP_TST ||
                                   decoded.op == adpalu_pkg::OP_TEQ ||
                                   decoded.op == adpalu_pkg::OP_CMP);
         if (decoded.set_flags) begin
            executed.flags = {res[31], (res == 32'd0), c, decoded.flags[0]};
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/arm_data_processing_alu.sv =====
// top level of the arm data-processing alu: front, decoupling queue, back,
// result queue; depends on adpalu_pkg, adpalu_front, adpalu_fifo, adpalu_back
`default_nettype none
// Executes one ARM data-processing instruction per beat: operand two is a
// rotated 8-bit immediate or rm shifted by an immediate or by rs, then the
// opcode is applied and N, Z, C are updated on request (V kept). Both sides
// behave as queues: push while full is low, pop while empty is low. One
// instruction is accepted every cycle while full is low; when nothing stalls,
// an accepted push is registered in the decode queue, passes the back end into
// the result queue and then waits at the head of the result queue until it is
// popped. The decoded-instruction queue holds QUEUE_DEPTH beats and the result
// queue RSP_DEPTH beats, so the input keeps accepting while results wait to
// be popped until both fill.
// The combinational execute path is the barrel shifter followed by the
// 33-bit adder in the back end. No configuration, no state between items.
module arm_data_processing_alu #(
   parameter int unsigned QUEUE_DEPTH = 2,
   parameter int unsigned RSP_DEPTH   = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request beat
   input  wire logic        push,
   output logic             full,
   input  wire logic [3:0]  req_op,
   input  wire logic        req_imm_flag,
   input  wire logic        req_set_flags,
   input  wire logic [11:0] req_operand2,
   input  wire logic [31:0] req_rn_value,
   input  wire logic [31:0] req_rm_value,
   input  wire logic [7:0]  req_rs_low_byte,
   input  wire logic [3:0]  req_dest_reg,
   input  wire logic [3:0]  req_flags_in,
   // result beat
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_result,
   output logic             rsp_write_enable,
   output logic [3:0]       rsp_dest_reg_out,
   output logic [3:0]       rsp_flags_out,
   output logic [1:0]       rsp_status
);
   localparam int unsigned DEC_W = $bits(adpalu_pkg::decoded_type);
   localparam int unsigned RES_W = $bits(adpalu_pkg::result_type);

   adpalu_pkg::decoded_type dec_in, dec_out;
   adpalu_pkg::result_type  exe_in, rsp_beat;
   logic                    q_empty;
   logic                    rq_full;
   logic                    issue;
   logic [DEC_W-1:0]        dec_bits;
   logic [RES_W-1:0]        rsp_bits;

   // front: classify the incoming beat
   adpalu_front u_front (
      .op          (req_op),
      .imm_flag    (req_imm_flag),
      .set_flags   (req_set_flags),
      .operand2    (req_operand2),
      .rn_value    (req_rn_value),
      .rm_value    (req_rm_value),
      .rs_low_byte (req_rs_low_byte),
      .dest_reg    (req_dest_reg),
      .flags_in    (req_flags_in),
      .decoded     (dec_in)
   );

   // decoupling queue between front and back
   adpalu_fifo #(
      .WIDTH (DEC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_dec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (dec_in),
      .full      (full),
      .pop       (issue),
      .pop_data  (dec_bits),
      .empty     (q_empty)
   );

   assign dec_out = adpalu_pkg::decoded_type'(dec_bits);

   // back issues whenever there is a decoded beat and room for its result
   assign issue = !q_empty && !rq_full;

   adpalu_back u_back (
      .decoded  (dec_out),
      .executed (exe_in)
   );

   // result queue, the registered output side
   adpalu_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (issue),
      .push_data (exe_in),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_beat         = adpalu_pkg::result_type'(rsp_bits);
   assign rsp_result       = rsp_beat.result;
   assign rsp_write_enable = rsp_beat.write_enable;
   assign rsp_dest_reg_out = rsp_beat.rd;
   assign rsp_flags_out    = rsp_beat.flags;
   assign rsp_status       = rsp_beat.status;

`ifndef SYNTH
   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // a rejected instruction never carries a result or a write-back
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != adpalu_pkg::ST_OK) |->
         (rsp_result == 32'd0 && !rsp_write_enable))
      else $error("rejected instruction produced a result");

   // a decoded beat stalled by a full result queue stays at the queue head
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!q_empty && rq_full && !pop) |=> (!q_empty && $stable(dec_bits)))
      else $error("decoded beat lost while back end stalled");
`endif

endmodule
`default_nettype wire

// ===== test/arm_data_processing_alu_tb.sv =====
// self-checking testbench for arm_data_processing_alu: directed and random
// instructions on the push/full side, results checked on the empty/pop side
// depends on adpalu_pkg and the arm_data_processing_alu rtl
`timescale 1ns / 100ps

module arm_data_processing_alu_tb;

   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;

   // one instruction beat as driven on the req ports
   typedef struct packed {
      logic [3:0]  op;
      logic        imm_flag;
      logic        set_flags;
      logic [11:0] operand2;
      logic [31:0] rn_value;
      logic [31:0] rm_value;
      logic [7:0]  rs_low_byte;
      logic [3:0]  dest_reg;
      logic [3:0]  flags_in;
   } instr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        push = 1'b0;
   logic        full;
   logic [3:0]  req_op = '0;
   logic        req_imm_flag = 1'b0;
   logic        req_set_flags = 1'b0;
   logic [11:0] req_operand2 = '0;
   logic [31:0] req_rn_value = '0;
   logic [31:0] req_rm_value = '0;
   logic [7:0]  req_rs_low_byte = '0;
   logic [3:0]  req_dest_reg = '0;
   logic [3:0]  req_flags_in = '0;

   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_result;
   logic        rsp_write_enable;
   logic [3:0]  rsp_dest_reg_out;
   logic [3:0]  rsp_flags_out;
   logic [1:0]  rsp_status;

   instr_type              pending_instrs[$];
   adpalu_pkg::result_type expected_results[$];

   int total_items  = 0;
   int pushed_count = 0;
   int fail_count   = 0;
   int cycle_count  = 0;
   int send_idle_pct;
   int recv_idle_pct;

   logic [3:0] legal_ops [10] = '{adpalu_pkg::OP_AND, adpalu_pkg::OP_EOR, adpalu_pkg::OP_SUB,
                                  adpalu_pkg::OP_RSB, adpalu_pkg::OP_ADD, adpalu_pkg::OP_TST,
                                  adpalu_pkg::OP_TEQ, adpalu_pkg::OP_CMP, adpalu_pkg::OP_ORR,
                                  adpalu_pkg::OP_MOV};

   arm_data_processing_alu dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_imm_flag     (req_imm_flag),
      .req_set_flags    (req_set_flags),
      .req_operand2     (req_operand2),
      .req_rn_value     (req_rn_value),
      .req_rm_value     (req_rm_value),
      .req_rs_low_byte  (req_rs_low_byte),
      .req_dest_reg     (req_dest_reg),
      .req_flags_in     (req_flags_in),
      .empty            (empty),
      .pop              (pop),
      .rsp_result       (rsp_result),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_reg_out (rsp_dest_reg_out),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_status       (rsp_status)
   );

   always #4 clock = ~clock;

   // barrel shifter: a zero amount passes the value and the old carry through
   function automatic logic [31:0] shift_operand(input logic [31:0] v,
                                                 input logic [1:0] kind,
                                                 input logic [7:0] amt,
                                                 input logic cin,
                                                 output logic cout);
      logic [31:0] shifted;
      logic [4:0]  rot;
      shifted = v;
      cout    = cin;
      rot     = amt[4:0];
      if (amt != 8'd0) begin
         case (kind)
            adpalu_pkg::SH_LSL: begin
               if (amt < 8'd32) begin
                  cout    = v[32 - amt];
                  shifted = v << amt;
               end else begin
                  // lsl by exactly 32 carries out bit 0, beyond that nothing
                  cout    = (amt == 8'd32) ? v[0] : 1'b0;
                  shifted = '0;
               end
            end
            adpalu_pkg::SH_LSR: begin
               if (amt < 8'd32) begin
                  cout    = v[amt - 1];
                  shifted = v >> amt;
               end else begin
                  cout    = (amt == 8'd32) ? v[31] : 1'b0;
                  shifted = '0;
               end
            end
            adpalu_pkg::SH_ASR: begin
               if (amt < 8'd32) begin
                  cout    = v[amt - 1];
                  shifted = $signed(v) >>> amt;
               end else begin
                  cout    = v[31];
                  shifted = {32{v[31]}};
               end
            end
            default: begin
               // ror by a nonzero multiple of 32 keeps the value, carries bit 31
               if (rot == 5'd0) begin
                  cout = v[31];
               end else begin
                  cout    = v[rot - 1];
                  shifted = (v >> rot) | (v << (32 - rot));
               end
            end
         endcase
      end
      return shifted;
   endfunction

   // what the alu should return for one instruction
   function automatic adpalu_pkg::result_type execute_instr(input instr_type i);
      adpalu_pkg::result_type r;
      logic [31:0] op2;
      logic [32:0] sum;
      logic        carry;
      logic        legal;
      r.result       = '0;
      r.write_enable = 1'b0;
      r.rd           = i.dest_reg;
      r.flags        = i.flags_in;
      r.status       = adpalu_pkg::ST_OK;
      op2            = '0;
      carry          = i.flags_in[1];
      case (i.op)
         adpalu_pkg::OP_AND, adpalu_pkg::OP_EOR, adpalu_pkg::OP_SUB,
         adpalu_pkg::OP_RSB, adpalu_pkg::OP_ADD, adpalu_pkg::OP_TST,
         adpalu_pkg::OP_TEQ, adpalu_pkg::OP_CMP, adpalu_pkg::OP_ORR,
         adpalu_pkg::OP_MOV: legal = 1'b1;
         default: legal = 1'b0;
      endcase
      // a bad opcode wins over a bad shift form
      if (!legal) begin
         r.status = adpalu_pkg::ST_BAD_OP;
      end else if (i.imm_flag) begin
         op2 = shift_operand({24'd0, i.operand2[7:0]}, adpalu_pkg::SH_ROR,
                             {3'd0, i.operand2[11:8], 1'b0}, i.flags_in[1], carry);
      end else if (!i.operand2[4]) begin
         op2 = shift_operand(i.rm_value, i.operand2[6:5], {3'd0, i.operand2[11:7]},
                             i.flags_in[1], carry);
      end else if (!i.operand2[7]) begin
         op2 = shift_operand(i.rm_value, i.operand2[6:5], i.rs_low_byte,
                             i.flags_in[1], carry);
      end else begin
         r.status = adpalu_pkg::ST_BAD_SHIFT;
      end
      if (r.status == adpalu_pkg::ST_OK) begin
         case (i.op)
            adpalu_pkg::OP_AND, adpalu_pkg::OP_TST: r.result = i.rn_value & op2;
            adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ: r.result = i.rn_value ^ op2;
            adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP: begin
               r.result = i.rn_value - op2;
               carry    = (i.rn_value >= op2);
            end
            adpalu_pkg::OP_RSB: begin
               r.result = op2 - i.rn_value;
               carry    = (op2 >= i.rn_value);
            end
            adpalu_pkg::OP_ADD: begin
               sum      = {1'b0, i.rn_value} + {1'b0, op2};
               r.result = sum[31:0];
               carry    = sum[32];
            end
            adpalu_pkg::OP_ORR: r.result = i.rn_value | op2;
            default: r.result = op2;
         endcase
         r.write_enable = !(i.op == adpalu_pkg::OP_TST || i.op == adpalu_pkg::OP_TEQ ||
                            i.op == adpalu_pkg::OP_CMP);
         if (i.set_flags)
            r.flags = {r.result[31], r.result == 32'd0, carry, i.flags_in[0]};
      end
      return r;
   endfunction

   function automatic instr_type make_instr(input logic [3:0] op, input logic imm,
                                            input logic sf, input logic [11:0] o2,
                                            input logic [31:0] rn, input logic [31:0] rm,
                                            input logic [7:0] rs, input logic [3:0] rd,
                                            input logic [3:0] fl);
      instr_type i;
      i = '{op, imm, sf, o2, rn, rm, rs, rd, fl};
      return i;
   endfunction

   // operand2 field: shift rm by rs, and shift rm by a 5-bit immediate
   function automatic logic [11:0] by_reg(input logic [1:0] kind);
      return {4'd0, 1'b0, kind, 1'b1, 4'd3};
   endfunction

   function automatic logic [11:0] by_imm(input logic [4:0] amt, input logic [1:0] kind);
      return {amt, kind, 1'b0, 4'd3};
   endfunction

   // mostly plain random words, now and then a corner value
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic instr_type random_instr();
      instr_type i;
      i.op = ($urandom_range(99) < 85) ? legal_ops[$urandom_range(9)]
                                       : 4'($urandom_range(15));
      i.imm_flag  = 1'($urandom_range(1));
      i.set_flags = ($urandom_range(99) < 70);
      i.operand2  = 12'($urandom);
      // keep most register-shift forms legal
      if (!i.imm_flag && i.operand2[4] && $urandom_range(99) < 80)
         i.operand2[7] = 1'b0;
      i.rn_value = pick_word();
      i.rm_value = pick_word();
      case ($urandom_range(2))
         0: i.rs_low_byte = 8'($urandom_range(40));
         1: i.rs_low_byte = 8'($urandom_range(1, 7) * 32 + $urandom_range(1));
         default: i.rs_low_byte = 8'($urandom);
      endcase
      // equal operands hit the borrow boundary of sub, rsb and cmp
      if ($urandom_range(9) == 0) begin
         i.imm_flag = 1'b0;
         i.operand2 = by_imm(5'd0, adpalu_pkg::SH_LSL);
         i.rn_value = i.rm_value;
      end
      i.dest_reg = 4'($urandom_range(15));
      i.flags_in = 4'($urandom_range(15));
      return i;
   endfunction

   // driver: presents the head of the pending list, holds a refused beat
   always @(posedge clock) begin : drive_beat
      instr_type nxt;
      logic      go;
      case (pushed_count * 3 / total_items)
         0:       send_idle_pct = 23;
         1:       send_idle_pct = 84;
         default: send_idle_pct = 0;
      endcase
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_results.push_back(execute_instr(pending_instrs.pop_front()));
            pushed_count++;
         end
         go = 1'b0;
         if (pending_instrs.size() != 0) begin
            if (push && full)
               go = 1'b1;
            else
               go = ($urandom_range(99) >= send_idle_pct);
         end
         if (go) begin
            nxt = pending_instrs[0];
            req_op          <= nxt.op;
            req_imm_flag    <= nxt.imm_flag;
            req_set_flags   <= nxt.set_flags;
            req_operand2    <= nxt.operand2;
            req_rn_value    <= nxt.rn_value;
            req_rm_value    <= nxt.rm_value;
            req_rs_low_byte <= nxt.rs_low_byte;
            req_dest_reg    <= nxt.dest_reg;
            req_flags_in    <= nxt.flags_in;
         end
         push <= go;
      end
   end

   // monitor: every popped beat is checked against the oldest expectation
   always @(posedge clock) begin : check_beat
      adpalu_pkg::result_type got;
      adpalu_pkg::result_type want;
      logic                   bad;
      // receiver stalls mirror the sender phases
      case (pushed_count * 3 / total_items)
         0:       recv_idle_pct = 84;
         1:       recv_idle_pct = 23;
         default: recv_idle_pct = 0;
      endcase
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_result, rsp_write_enable, rsp_dest_reg_out, rsp_flags_out, rsp_status};
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result beat: result %h we %b rd %h flags %b st %0d",
                           got.result, got.write_enable, got.rd, got.flags, got.status);
            end else begin
               want = expected_results.pop_front();
               bad  = (got.result !== want.result) ||
                      (got.write_enable !== want.write_enable) ||
                      (got.rd !== want.rd) ||
                      (got.flags !== want.flags) ||
                      (got.status !== want.status);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("wrong result beat: exp result %h we %b rd %h flags %b st %0d",
                              want.result, want.write_enable, want.rd, want.flags,
                              want.status);
                     $display("                   got result %h we %b rd %h flags %b st %0d",
                              got.result, got.write_enable, got.rd, got.flags, got.status);
                  end
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("arm_data_processing_alu: mismatch");
         $finish;
      end
   end

   initial begin
      // every opcode once, legal and illegal, with a mix of operand forms
      for (int k = 0; k < 16; k++)
         pending_instrs.push_back(make_instr(4'(k), k[0], 1'b1, 12'(k * 263),
                                             32'h8000_0001 + k, 32'hC000_0003,
                                             8'(k * 3), 4'(k), 4'(k)));
      // register shifts of 32 and beyond
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_MOV, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_LSL),
                                          '0, 32'h0000_0001, 8'd32, 4'd1, 4'b0000));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_MOV, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_LSR),
                                          '0, 32'h8000_0000, 8'd32, 4'd2, 4'b0001));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_MOV, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_LSR),
                                          '0, 32'hFFFF_FFFF, 8'd33, 4'd3, 4'b0010));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_MOV, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_ASR),
                                          '0, 32'h8000_1234, 8'd200, 4'd4, 4'b0000));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_ORR, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_ROR),
                                          '0, 32'h8765_4321, 8'd64, 4'd5, 4'b0000));
      // zero shift amounts keep the old carry
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_AND, 1'b0, 1'b1,
                                          by_reg(adpalu_pkg::SH_ROR),
                                          32'hFFFF_FFFF, 32'h0000_00F0, 8'd0, 4'd6,
                                          4'b0010));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_EOR, 1'b0, 1'b1,
                                          by_imm(5'd0, adpalu_pkg::SH_LSR),
                                          '0, 32'h8000_0000, 8'd0, 4'd7, 4'b0011));
      // immediate with the largest rotation
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_MOV, 1'b1, 1'b1, 12'hFFF,
                                          '0, '0, '0, 4'd8, 4'b0000));
      // unsupported shift form, alone and behind a bad opcode
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_ADD, 1'b0, 1'b1, 12'h093,
                                          32'd5, 32'd7, 8'd1, 4'd9, 4'b1010));
      pending_instrs.push_back(make_instr(4'(adpalu_pkg::OP_ADD + 1), 1'b0, 1'b1, 12'h093,
                                          32'd5, 32'd7, 8'd1, 4'd10, 4'b0101));
      // carry and borrow boundaries, flags left alone without set_flags
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_CMP, 1'b0, 1'b1,
                                          by_imm(5'd0, adpalu_pkg::SH_LSL),
                                          32'h1234_5678, 32'h1234_5678, '0, 4'd11,
                                          4'b0000));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_ADD, 1'b1, 1'b1, 12'h001,
                                          32'hFFFF_FFFF, '0, '0, 4'd12, 4'b0001));
      pending_instrs.push_back(make_instr(adpalu_pkg::OP_RSB, 1'b1, 1'b0, 12'h001,
                                          32'd2, '0, '0, 4'd15, 4'b1111));
      for (int k = 0; k < RANDOM_ITEMS; k++)
         pending_instrs.push_back(random_instr());
      total_items = pending_instrs.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || push || expected_results.size() != 0)
         @(posedge clock);
      // stray beats after the last one would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0)
         $display("arm_data_processing_alu: match");
      else
         $display("arm_data_processing_alu: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
design/adpalu_pkg.sv
design/adpalu_fifo.sv
design/adpalu_front.sv
design/adpalu_back.sv
design/arm_data_processing_alu.sv
test/arm_data_processing_alu_tb.sv
